FILE: rtl/sbct_pkg.sv
// Shared widths and helpers for the swept box collision test block.
// Depends on nothing; used by rtl/swept_box_collision_test_top.sv.
package sbct_pkg;

  localparam int POS_W  = 24;  // signed Q16.8 positions and results
  localparam int SIZE_W = 16;  // unsigned Q8.8 sizes and step size
  localparam int VEL_W  = 20;  // signed Q12.8 velocity
  localparam int RAD_W  = 40;  // squared velocity length
  localparam int ROOT_W = 20;  // root, quotients, per-step offsets
  localparam int REM_W  = 21;  // shared unit partial remainder
  localparam int UNIT_W = 23;  // shared unit shifted operand
  localparam int PX_W   = 26;  // sample centre before saturation
  localparam int DIST_W = 27;  // absolute centre distance
  localparam int OVL_W  = 29;  // doubled overlap
  localparam int SUM_W  = 17;  // size sum

  localparam logic signed [OVL_W-1:0] SAT_HI = OVL_W'(8388607);
  localparam logic signed [OVL_W-1:0] SAT_LO = -OVL_W'(8388608);

  // Saturate a wide signed value to the 24-bit signed result range.
  function automatic logic [POS_W-1:0] sat24(input logic signed [OVL_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v > SAT_HI) begin
      r = POS_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = POS_W'(SAT_LO);
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/swept_box_collision_test_top.sv
// Swept axis-aligned box collision test, sequenced over one shared
// compare-subtract unit. Depends on rtl/sbct_pkg.sv.
//
//   channel | direction | handshake          | carries
//   --------+-----------+--------------------+-------------------------------
//   in_     | input     | in_valid/in_stall  | fixed box, mover, velocity
//   out_    | output    | out_valid/out_stall| hit flag, hit centre, overlaps
//   cfg_    | input     | cfg_valid/cfg_ready| step_size register
//
// A request is squared, its root taken, the step count divided out, the two
// offsets divided, then each of k samples placed, measured and tested, and
// the result handed over. k runs from 1 to n+1, n at most MAX_STEPS; the step
// count division is skipped when step_size is zero. One shared compare-subtract
// unit runs the square root and the three divisions a bit per cycle.
// Reset (rst_n low, synchronous) empties the block and restores step_size to
// 4096. A stall on out_ holds the finished result; the next request is taken
// meanwhile and waits for the output register before finishing.
module swept_box_collision_test_top #(
  parameter int MAX_STEPS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_block_x,
  input  logic [23:0] in_block_y,
  input  logic [15:0] in_block_width,
  input  logic [15:0] in_block_height,
  input  logic [23:0] in_mover_x,
  input  logic [23:0] in_mover_y,
  input  logic [15:0] in_mover_width,
  input  logic [15:0] in_mover_height,
  input  logic [19:0] in_velocity_x,
  input  logic [19:0] in_velocity_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [23:0] out_hit_x,
  output logic [23:0] out_hit_y,
  output logic [23:0] out_overlap_x,
  output logic [23:0] out_overlap_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_step_size
);

  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int CW = $clog2(sbct_pkg::ROOT_W);
  localparam logic [CW-1:0] LAST_BIT = CW'(sbct_pkg::ROOT_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_SQRT, ST_DIVN, ST_DIVX, ST_DIVY,
    ST_POS, ST_DIST, ST_OVL, ST_DONE
  } state_t;

  state_t state_r;
  logic [sbct_pkg::SIZE_W-1:0] step_r;

  // Captured request.
  logic [sbct_pkg::POS_W-1:0] bx_r, by_r, mx_r, my_r;
  logic [sbct_pkg::SUM_W-1:0] sw_r, sh_r;
  logic [sbct_pkg::VEL_W-1:0] vx_r, vy_r;

  // Shared unit operands.
  logic [sbct_pkg::RAD_W-1:0]  dvd_r;
  logic [sbct_pkg::REM_W-1:0]  rem_r;
  logic [sbct_pkg::ROOT_W-1:0] quo_r;
  logic [sbct_pkg::SIZE_W-1:0] div_r;
  logic [CW-1:0]               cnt_r;

  // Sample walk.
  logic [NW-1:0]               n_r, i_r;
  logic [sbct_pkg::ROOT_W-1:0] qa_x_r, qa_y_r, qx_r, qy_r;
  logic [NW:0]                 ra_x_r, ra_y_r, rx_r, ry_r;
  logic [sbct_pkg::PX_W-1:0]   px_r, py_r;
  logic [sbct_pkg::DIST_W-1:0] adx_r, ady_r;
  logic [sbct_pkg::OVL_W-1:0]  ox_r, oy_r;
  logic                        hit_r;

  // Output register.
  logic                       out_valid_r, out_hit_r;
  logic [sbct_pkg::POS_W-1:0] out_hx_r, out_hy_r, out_ox_r, out_oy_r;

  // The shared compare-subtract unit: one square root digit or one divide bit.
  logic                        sqrt_mode;
  logic [sbct_pkg::UNIT_W-1:0] unit_shift, unit_trial;
  logic [sbct_pkg::UNIT_W:0]   unit_diff;
  logic                        unit_ge;
  logic [sbct_pkg::REM_W-1:0]  rem_nxt;
  logic [sbct_pkg::ROOT_W-1:0] quo_nxt;

  assign sqrt_mode  = (state_r == ST_SQRT);
  assign unit_shift = sqrt_mode ? {rem_r, dvd_r[sbct_pkg::RAD_W-1 -: 2]}
                                : {1'b0, rem_r, dvd_r[sbct_pkg::RAD_W-1]};
  assign unit_trial = sqrt_mode ? {1'b0, quo_r, 2'b01}
                                : {(sbct_pkg::UNIT_W - sbct_pkg::SIZE_W)'(0), div_r};
  assign unit_diff  = {1'b0, unit_shift} - {1'b0, unit_trial};
  assign unit_ge    = ~unit_diff[sbct_pkg::UNIT_W];
  assign rem_nxt    = unit_ge ? unit_diff[sbct_pkg::REM_W-1:0]
                              : unit_shift[sbct_pkg::REM_W-1:0];
  assign quo_nxt    = {quo_r[sbct_pkg::ROOT_W-2:0], unit_ge};

  // Squaring uses one 20 by 20 multiplier, once per axis.
  logic signed [sbct_pkg::VEL_W-1:0]   mul_a;
  logic signed [2*sbct_pkg::VEL_W-1:0] mul_p;
  assign mul_a = $signed((state_r == ST_SQX) ? vx_r : vy_r);
  assign mul_p = mul_a * mul_a;

  // Step count from the quotient, capped, and at least one so that a zero
  // count walks start then full move.
  logic [NW-1:0] n_calc;
  always_comb begin
    if (quo_nxt > sbct_pkg::ROOT_W'(MAX_STEPS)) begin
      n_calc = NW'(MAX_STEPS);
    end else if (quo_nxt == '0) begin
      n_calc = NW'(1);
    end else begin
      n_calc = quo_nxt[NW-1:0];
    end
  end

  // Velocity magnitudes.
  logic [sbct_pkg::ROOT_W-1:0] abs_vx, abs_vy;
  assign abs_vx = vx_r[sbct_pkg::VEL_W-1] ? (sbct_pkg::ROOT_W'(0) - vx_r) : vx_r;
  assign abs_vy = vy_r[sbct_pkg::VEL_W-1] ? (sbct_pkg::ROOT_W'(0) - vy_r) : vy_r;

  // Offset accumulators: q tracks round(|v|*i/n), r the remainder over 2n.
  logic [NW:0]   two_n;
  logic [NW+1:0] rx_sum, ry_sum;
  logic          rx_wrap, ry_wrap;
  assign two_n   = {n_r, 1'b0};
  assign rx_sum  = {1'b0, rx_r} + {1'b0, ra_x_r};
  assign ry_sum  = {1'b0, ry_r} + {1'b0, ra_y_r};
  assign rx_wrap = (rx_sum >= {1'b0, two_n});
  assign ry_wrap = (ry_sum >= {1'b0, two_n});

  // Sample centre from the current offset.
  logic [sbct_pkg::PX_W-1:0] offx, offy, px_calc, py_calc;
  always_comb begin
    offx = {(sbct_pkg::PX_W - sbct_pkg::ROOT_W)'(0), qx_r};
    offy = {(sbct_pkg::PX_W - sbct_pkg::ROOT_W)'(0), qy_r};
    if (vx_r[sbct_pkg::VEL_W-1]) begin
      offx = sbct_pkg::PX_W'(0) - offx;
    end
    if (vy_r[sbct_pkg::VEL_W-1]) begin
      offy = sbct_pkg::PX_W'(0) - offy;
    end
    px_calc = {{2{mx_r[sbct_pkg::POS_W-1]}}, mx_r} + offx;
    py_calc = {{2{my_r[sbct_pkg::POS_W-1]}}, my_r} + offy;
  end

  // Absolute centre distance.
  logic [sbct_pkg::DIST_W-1:0] dx, dy;
  assign dx = {{3{bx_r[sbct_pkg::POS_W-1]}}, bx_r} - {px_r[sbct_pkg::PX_W-1], px_r};
  assign dy = {{3{by_r[sbct_pkg::POS_W-1]}}, by_r} - {py_r[sbct_pkg::PX_W-1], py_r};

  // Doubled overlap: size sum minus twice the distance.
  logic [sbct_pkg::OVL_W-1:0] ox_calc, oy_calc;
  logic                       hit_calc;
  assign ox_calc = {(sbct_pkg::OVL_W - sbct_pkg::SUM_W)'(0), sw_r} - {1'b0, adx_r, 1'b0};
  assign oy_calc = {(sbct_pkg::OVL_W - sbct_pkg::SUM_W)'(0), sh_r} - {1'b0, ady_r, 1'b0};
  assign hit_calc = ($signed(ox_calc) > 0) && ($signed(oy_calc) > 0);

  logic out_free;
  assign out_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= sbct_pkg::SIZE_W'(4096);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        step_r <= cfg_step_size;
      end
      // A finished request refills the output register in the same cycle
      // that the previous result leaves it.
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            bx_r    <= in_block_x;
            by_r    <= in_block_y;
            mx_r    <= in_mover_x;
            my_r    <= in_mover_y;
            sw_r    <= {1'b0, in_block_width} + {1'b0, in_mover_width};
            sh_r    <= {1'b0, in_block_height} + {1'b0, in_mover_height};
            vx_r    <= in_velocity_x;
            vy_r    <= in_velocity_y;
            state_r <= ST_SQX;
          end
        end
        ST_SQX: begin
          dvd_r   <= mul_p;
          state_r <= ST_SQY;
        end
        ST_SQY: begin
          dvd_r   <= dvd_r + mul_p;
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          if (cnt_r == LAST_BIT) begin
            rem_r <= '0;
            quo_r <= '0;
            cnt_r <= '0;
            if (step_r == '0) begin
              n_r     <= NW'(MAX_STEPS);
              div_r   <= sbct_pkg::SIZE_W'(MAX_STEPS);
              dvd_r   <= {abs_vx, (sbct_pkg::RAD_W - sbct_pkg::ROOT_W)'(0)};
              state_r <= ST_DIVX;
            end else begin
              div_r   <= step_r;
              dvd_r   <= {quo_nxt, (sbct_pkg::RAD_W - sbct_pkg::ROOT_W)'(0)};
              state_r <= ST_DIVN;
            end
          end else begin
            rem_r <= rem_nxt;
            quo_r <= quo_nxt;
            dvd_r <= {dvd_r[sbct_pkg::RAD_W-3:0], 2'b00};
            cnt_r <= cnt_r + CW'(1);
          end
        end
        ST_DIVN, ST_DIVX, ST_DIVY: begin
          if (cnt_r == LAST_BIT) begin
            rem_r <= '0;
            quo_r <= '0;
            cnt_r <= '0;
            if (state_r == ST_DIVN) begin
              n_r     <= n_calc;
              div_r   <= sbct_pkg::SIZE_W'(n_calc);
              dvd_r   <= {abs_vx, (sbct_pkg::RAD_W - sbct_pkg::ROOT_W)'(0)};
              state_r <= ST_DIVX;
            end else if (state_r == ST_DIVX) begin
              qa_x_r  <= quo_nxt;
              ra_x_r  <= {rem_nxt[NW-1:0], 1'b0};
              dvd_r   <= {abs_vy, (sbct_pkg::RAD_W - sbct_pkg::ROOT_W)'(0)};
              state_r <= ST_DIVY;
            end else begin
              qa_y_r  <= quo_nxt;
              ra_y_r  <= {rem_nxt[NW-1:0], 1'b0};
              qx_r    <= '0;
              qy_r    <= '0;
              rx_r    <= {1'b0, n_r};
              ry_r    <= {1'b0, n_r};
              i_r     <= '0;
              state_r <= ST_POS;
            end
          end else begin
            rem_r <= rem_nxt;
            quo_r <= quo_nxt;
            dvd_r <= {dvd_r[sbct_pkg::RAD_W-2:0], 1'b0};
            cnt_r <= cnt_r + CW'(1);
          end
        end
        ST_POS: begin
          px_r <= px_calc;
          py_r <= py_calc;
          // Advance the offsets to the next sample.
          qx_r <= qx_r + qa_x_r + sbct_pkg::ROOT_W'(rx_wrap);
          qy_r <= qy_r + qa_y_r + sbct_pkg::ROOT_W'(ry_wrap);
          rx_r <= rx_wrap ? (NW+1)'(rx_sum - {1'b0, two_n}) : rx_sum[NW:0];
          ry_r <= ry_wrap ? (NW+1)'(ry_sum - {1'b0, two_n}) : ry_sum[NW:0];
          state_r <= ST_DIST;
        end
        ST_DIST: begin
          adx_r   <= dx[sbct_pkg::DIST_W-1] ? (sbct_pkg::DIST_W'(0) - dx) : dx;
          ady_r   <= dy[sbct_pkg::DIST_W-1] ? (sbct_pkg::DIST_W'(0) - dy) : dy;
          state_r <= ST_OVL;
        end
        ST_OVL: begin
          ox_r  <= ox_calc;
          oy_r  <= oy_calc;
          hit_r <= hit_calc;
          if (hit_calc || (i_r == n_r)) begin
            state_r <= ST_DONE;
          end else begin
            i_r     <= i_r + NW'(1);
            state_r <= ST_POS;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_hit_r   <= hit_r;
            out_hx_r    <= sbct_pkg::sat24($signed({{3{px_r[sbct_pkg::PX_W-1]}}, px_r}));
            out_hy_r    <= sbct_pkg::sat24($signed({{3{py_r[sbct_pkg::PX_W-1]}}, py_r}));
            out_ox_r    <= sbct_pkg::sat24($signed(ox_r) >>> 1);
            out_oy_r    <= sbct_pkg::sat24($signed(oy_r) >>> 1);
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_hit_x     = out_hx_r;
  assign out_hit_y     = out_hy_r;
  assign out_overlap_x = out_ox_r;
  assign out_overlap_y = out_oy_r;

  // An accepted request always makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted request did not start the sequencer");

  // A new result appears only when the sequencer hands one over.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result appeared without a finished request");

  // The sample walk stays within the step count and its remainders below 2n.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POS) |-> (i_r <= n_r && rx_r < two_n && ry_r < two_n
                             && n_r != '0))
    else $error("sample walk left its range");

endmodule
